>>> rtl/mlfq_pkg.sv
// Package for the multilevel feedback queue scheduler.
// Holds the sizes, field widths, command and status codes and the helper functions.
// The slice and top-level rtl files use it through scoped names; mlfq_ram does not.
package mlfq_pkg;

  localparam int NUM_LEVELS    = 8;
  localparam int QUEUE_DEPTH   = 16;

  localparam int LVL_W         = $clog2(NUM_LEVELS);
  localparam int PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W        = $clog2(NUM_LEVELS * QUEUE_DEPTH);
  localparam int ENT_DEPTH     = NUM_LEVELS * QUEUE_DEPTH;

  localparam int ID_W          = 8;
  localparam int REM_W         = 16;
  localparam int TICK_W        = 8;
  localparam int OUT_LVL_W     = 3;
  localparam int STAT_W        = 2;
  localparam int ENTRY_W       = ID_W + REM_W;

  localparam logic [TICK_W-1:0] QUANTUM_RESET = 8'd10;

  localparam logic CMD_START    = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROP  = 2'd2;

  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(NUM_LEVELS - 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic              fin;
    logic [TICK_W-1:0] ticks;
    logic [REM_W-1:0]  rem_left;
    logic [LVL_W-1:0]  tgt;
  } slice_res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_MAX) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] ent_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [PTR_W-1:0] ptr);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
    return a;
  endfunction

  // low bits of a level, zero-extended when levels are fewer than eight
  function automatic logic [OUT_LVL_W-1:0] out_lvl(input logic [LVL_W-1:0] lvl);
    logic [LVL_W+OUT_LVL_W-1:0] t;
    t = (LVL_W + OUT_LVL_W)'(lvl);
    return t[OUT_LVL_W-1:0];
  endfunction

endpackage

>>> rtl/mlfq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Used for the queue entry store; no package dependency.
module mlfq_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/mlfq_slice.sv
// One time slice of a task: ticks run, finish decision, remaining ticks and demotion level.
// Depends on mlfq_pkg.
module mlfq_slice (
  input  logic [mlfq_pkg::REM_W-1:0]  remaining,
  input  logic [mlfq_pkg::LVL_W-1:0]  from_lvl,
  input  logic [mlfq_pkg::TICK_W-1:0] quantum,
  output mlfq_pkg::slice_res_t        res
);

  logic [mlfq_pkg::TICK_W-1:0] q_eff;

  always_comb begin
    // a zero quantum behaves as one tick
    q_eff        = (quantum == '0) ? mlfq_pkg::TICK_W'(1) : quantum;
    res.fin      = (remaining <= mlfq_pkg::REM_W'(q_eff));
    res.ticks    = res.fin ? remaining[mlfq_pkg::TICK_W-1:0] : q_eff;
    res.rem_left = remaining - mlfq_pkg::REM_W'(q_eff);
    res.tgt      = (from_lvl == mlfq_pkg::LVL_MAX) ? from_lvl : from_lvl + 1'b1;
  end

endmodule

>>> rtl/multilevel_feedback_queue_scheduler.sv
// Top level of the multilevel feedback queue scheduler: sequencer, queue pointers, output.
// Depends on mlfq_pkg, mlfq_ram and mlfq_slice.
//
//  channel   ports                                      transfer
//  input     start, busy, in_command, in_run_length     start & !busy
//  result    out_valid, out_task_id .. out_last         out_valid, one cycle each
//  config    cfg_valid, cfg_ready, cfg_data             cfg_valid & cfg_ready
//
// A start command leaves busy low; its result is registered and appears the next cycle.
// A dispatch pops every entry of the chosen level (1 to QUEUE_DEPTH) in turn through the
// one read port of the entry RAM; results stream one per cycle, each passing through the
// RAM read register and the output register. An empty dispatch gives one status result.
// Reset is synchronous; the entry RAM is not cleared. The receiver cannot stall.
module multilevel_feedback_queue_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [mlfq_pkg::REM_W-1:0]        in_run_length,
  output logic                              out_valid,
  output logic [mlfq_pkg::ID_W-1:0]         out_task_id,
  output logic [mlfq_pkg::TICK_W-1:0]       out_ticks_run,
  output logic                              out_finished,
  output logic [mlfq_pkg::OUT_LVL_W-1:0]    out_level,
  output logic [mlfq_pkg::STAT_W-1:0]       out_status,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlfq_pkg::TICK_W-1:0]       cfg_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                          state_r, state_nxt;
  logic [mlfq_pkg::TICK_W-1:0]   quantum_r;
  logic [mlfq_pkg::ID_W-1:0]     task_cnt_r, task_cnt_nxt;
  logic [mlfq_pkg::LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [mlfq_pkg::CNT_W-1:0]    left_r, left_nxt;

  logic [mlfq_pkg::PTR_W-1:0]    head_r [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::PTR_W-1:0]    head_nxt [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::PTR_W-1:0]    tail_r [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::PTR_W-1:0]    tail_nxt [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::CNT_W-1:0]    cnt_r [mlfq_pkg::NUM_LEVELS];
  logic [mlfq_pkg::CNT_W-1:0]    cnt_nxt [mlfq_pkg::NUM_LEVELS];

  logic                          acc;
  logic                          sel_found;
  logic [mlfq_pkg::LVL_W-1:0]    sel_lvl;
  logic                          slice_act;
  logic [mlfq_pkg::REM_W-1:0]    sl_rem;
  logic [mlfq_pkg::LVL_W-1:0]    sl_from;
  logic [mlfq_pkg::ID_W-1:0]     sl_id;
  mlfq_pkg::slice_res_t          sl_res;
  logic                          full;
  logic                          push;
  logic                          pop;
  logic [mlfq_pkg::LVL_W-1:0]    pop_lv;
  logic [mlfq_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [mlfq_pkg::ADDR_W-1:0]   ram_raddr;
  logic [mlfq_pkg::ADDR_W-1:0]   ram_waddr;
  logic [mlfq_pkg::ENTRY_W-1:0]  ram_wdata;

  logic                          out_valid_r, out_valid_nxt;
  logic [mlfq_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic [mlfq_pkg::TICK_W-1:0]   out_ticks_r, out_ticks_nxt;
  logic                          out_fin_r, out_fin_nxt;
  logic [mlfq_pkg::OUT_LVL_W-1:0] out_lvl_r, out_lvl_nxt;
  logic [mlfq_pkg::STAT_W-1:0]   out_stat_r, out_stat_nxt;
  logic                          out_last_r, out_last_nxt;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign acc       = start && (state_r == S_IDLE);

  // lowest-numbered non-empty level
  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int i = mlfq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        sel_found = 1'b1;
        sel_lvl   = mlfq_pkg::LVL_W'(i);
      end
    end
  end

  always_comb begin
    if (state_r == S_RUN) begin
      sl_rem  = ram_rdata[mlfq_pkg::REM_W-1:0];
      sl_from = lvl_r;
      sl_id   = ram_rdata[mlfq_pkg::ENTRY_W-1 -: mlfq_pkg::ID_W];
    end else begin
      sl_rem  = in_run_length;
      sl_from = '0;
      sl_id   = task_cnt_r + 1'b1;
    end
  end

  mlfq_slice u_slice (
    .remaining (sl_rem),
    .from_lvl  (sl_from),
    .quantum   (quantum_r),
    .res       (sl_res)
  );

  always_comb begin
    slice_act = (acc && in_command == mlfq_pkg::CMD_START) || (state_r == S_RUN);
    full      = (cnt_r[sl_res.tgt] >= mlfq_pkg::CNT_W'(mlfq_pkg::QUEUE_DEPTH));
    push      = slice_act && !sl_res.fin && !full;
    ram_waddr = mlfq_pkg::ent_addr(sl_res.tgt, tail_r[sl_res.tgt]);
    ram_wdata = {sl_id, sl_res.rem_left};

    pop    = 1'b0;
    pop_lv = lvl_r;
    if (acc && in_command == mlfq_pkg::CMD_DISPATCH && sel_found) begin
      pop    = 1'b1;
      pop_lv = sel_lvl;
    end else if (state_r == S_RUN && left_r != '0) begin
      pop    = 1'b1;
      pop_lv = lvl_r;
    end
    ram_raddr = mlfq_pkg::ent_addr(pop_lv, head_r[pop_lv]);
  end

  // pop and push may hit the same level when the lowest level feeds itself
  always_comb begin
    for (int i = 0; i < mlfq_pkg::NUM_LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
      if (push && sl_res.tgt == mlfq_pkg::LVL_W'(i)) begin
        tail_nxt[i] = mlfq_pkg::ptr_inc(tail_r[i]);
        cnt_nxt[i]  = cnt_nxt[i] + 1'b1;
      end
      if (pop && pop_lv == mlfq_pkg::LVL_W'(i)) begin
        head_nxt[i] = mlfq_pkg::ptr_inc(head_r[i]);
        cnt_nxt[i]  = cnt_nxt[i] - 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    task_cnt_nxt = task_cnt_r;
    lvl_nxt      = lvl_r;
    left_nxt     = left_r;
    case (state_r)
      S_IDLE: begin
        if (acc && in_command == mlfq_pkg::CMD_START) begin
          task_cnt_nxt = task_cnt_r + 1'b1;
        end else if (acc && sel_found) begin
          state_nxt = S_RUN;
          lvl_nxt   = sel_lvl;
          left_nxt  = cnt_r[sel_lvl] - 1'b1;
        end
      end
      S_RUN: begin
        if (left_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          left_nxt = left_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = slice_act || (acc && in_command == mlfq_pkg::CMD_DISPATCH && !sel_found);
    out_id_nxt    = sl_id;
    out_ticks_nxt = sl_res.ticks;
    out_fin_nxt   = sl_res.fin;
    out_lvl_nxt   = sl_res.fin ? '0 : mlfq_pkg::out_lvl(sl_res.tgt);
    out_stat_nxt  = (!sl_res.fin && full) ? mlfq_pkg::ST_DROP : mlfq_pkg::ST_OK;
    out_last_nxt  = (state_r == S_RUN) ? (left_r == '0) : 1'b1;
    if (!slice_act) begin
      // empty dispatch
      out_id_nxt    = '0;
      out_ticks_nxt = '0;
      out_fin_nxt   = 1'b0;
      out_lvl_nxt   = '0;
      out_stat_nxt  = mlfq_pkg::ST_EMPTY;
      out_last_nxt  = 1'b1;
    end
  end

  mlfq_ram #(
    .DATA_W (mlfq_pkg::ENTRY_W),
    .DEPTH  (mlfq_pkg::ENT_DEPTH),
    .ADDR_W (mlfq_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      task_cnt_r  <= '0;
      quantum_r   <= mlfq_pkg::QUANTUM_RESET;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
      left_r      <= '0;
      for (int i = 0; i < mlfq_pkg::NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      task_cnt_r  <= task_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      left_r      <= left_nxt;
      if (cfg_valid && cfg_ready) begin
        quantum_r <= cfg_data;
      end
      for (int i = 0; i < mlfq_pkg::NUM_LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_id_r    <= out_id_nxt;
    out_ticks_r <= out_ticks_nxt;
    out_fin_r   <= out_fin_nxt;
    out_lvl_r   <= out_lvl_nxt;
    out_stat_r  <= out_stat_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_task_id   = out_id_r;
  assign out_ticks_run = out_ticks_r;
  assign out_finished  = out_fin_r;
  assign out_level     = out_lvl_r;
  assign out_status    = out_stat_r;
  assign out_last      = out_last_r;

endmodule

>>> dv/tb_multilevel_feedback_queue_scheduler.sv
`timescale 1ns / 100ps
// Self-checking testbench for multilevel_feedback_queue_scheduler.
// Uses mlfq_pkg for widths and codes; a scoreboard class predicts every slice result.

module tb_multilevel_feedback_queue_scheduler;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = mlfq_pkg::QUEUE_DEPTH + 4;
  localparam int PHASE_ITEMS   = 67;

  typedef struct packed {
    logic [mlfq_pkg::ID_W-1:0]      task_id;
    logic [mlfq_pkg::TICK_W-1:0]    ticks_run;
    logic                           finished;
    logic [mlfq_pkg::OUT_LVL_W-1:0] level;
    logic [mlfq_pkg::STAT_W-1:0]    status;
    logic                           last;
  } slice_t;

  class slice_scoreboard;
    logic [mlfq_pkg::ID_W-1:0]   slot_id [mlfq_pkg::NUM_LEVELS][mlfq_pkg::QUEUE_DEPTH];
    logic [mlfq_pkg::REM_W-1:0]  slot_rem [mlfq_pkg::NUM_LEVELS][mlfq_pkg::QUEUE_DEPTH];
    int unsigned                 head [mlfq_pkg::NUM_LEVELS];
    int unsigned                 tail [mlfq_pkg::NUM_LEVELS];
    int unsigned                 fill [mlfq_pkg::NUM_LEVELS];
    logic [mlfq_pkg::ID_W-1:0]   id_counter;
    logic [mlfq_pkg::TICK_W-1:0] quantum;
    slice_t                      expected_slices [$];
    int unsigned                 error_count;

    function new();
      id_counter  = '0;
      quantum     = mlfq_pkg::QUANTUM_RESET;
      error_count = 0;
      foreach (head[i]) begin
        head[i] = 0;
        tail[i] = 0;
        fill[i] = 0;
      end
    endfunction

    // One quantum of a task that came from level from_lvl; requeues it if time is left and the target level has room.
    function slice_t predict_slice(logic [mlfq_pkg::ID_W-1:0] id,
                                   logic [mlfq_pkg::REM_W-1:0] remaining,
                                   int unsigned from_lvl);
      slice_t                      s;
      logic [mlfq_pkg::TICK_W-1:0] q;
      int unsigned                 lvl;
      q = (quantum == '0) ? mlfq_pkg::TICK_W'(1) : quantum;
      s = '0;
      s.task_id = id;
      if (remaining <= mlfq_pkg::REM_W'(q)) begin
        s.ticks_run = remaining[mlfq_pkg::TICK_W-1:0];
        s.finished  = 1'b1;
        s.status    = mlfq_pkg::ST_OK;
        return s;
      end
      lvl = (from_lvl + 1 > mlfq_pkg::NUM_LEVELS - 1) ? mlfq_pkg::NUM_LEVELS - 1
                                                      : from_lvl + 1;
      s.ticks_run = q;
      s.level     = mlfq_pkg::OUT_LVL_W'(lvl);
      if (fill[lvl] >= mlfq_pkg::QUEUE_DEPTH) begin
        s.status = mlfq_pkg::ST_DROP;
      end else begin
        slot_id[lvl][tail[lvl]]  = id;
        slot_rem[lvl][tail[lvl]] = remaining - mlfq_pkg::REM_W'(q);
        tail[lvl] = (tail[lvl] + 1) % mlfq_pkg::QUEUE_DEPTH;
        fill[lvl]++;
        s.status = mlfq_pkg::ST_OK;
      end
      return s;
    endfunction

    function void note_command(logic cmd, logic [mlfq_pkg::REM_W-1:0] run_length);
      slice_t                     run [$];
      slice_t                     s;
      int unsigned                lv;
      int unsigned                n;
      logic [mlfq_pkg::ID_W-1:0]  id;
      logic [mlfq_pkg::REM_W-1:0] rem;
      if (cmd == mlfq_pkg::CMD_START) begin
        id_counter++;
        s = predict_slice(id_counter, run_length, 0);
        run = {run, s};
      end else begin
        lv = 0;
        while (lv < mlfq_pkg::NUM_LEVELS && fill[lv] == 0) lv++;
        if (lv == mlfq_pkg::NUM_LEVELS) begin
          s = '0;
          s.status = mlfq_pkg::ST_EMPTY;
          run = {run, s};
        end else begin
          // snapshot: entries requeued into this same level wait for the next dispatch
          n = fill[lv];
          repeat (n) begin
            id  = slot_id[lv][head[lv]];
            rem = slot_rem[lv][head[lv]];
            head[lv] = (head[lv] + 1) % mlfq_pkg::QUEUE_DEPTH;
            fill[lv]--;
            s = predict_slice(id, rem, lv);
            run = {run, s};
          end
        end
      end
      foreach (run[i]) begin
        s = run[i];
        s.last = (i == run.size() - 1);
        expected_slices = {expected_slices, s};
      end
    endfunction

    function int unsigned pending();
      return expected_slices.size();
    endfunction

    function void compare_field(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
    endfunction

    function void check_slice(slice_t got);
      slice_t want;
      if (expected_slices.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual id %0d status %0d",
                 $time, got.task_id, got.status);
        return;
      end
      want = expected_slices[0];
      expected_slices.delete(0);
      compare_field("task_id", want.task_id, got.task_id);
      compare_field("ticks_run", want.ticks_run, got.ticks_run);
      compare_field("finished", want.finished, got.finished);
      compare_field("level", want.level, got.level);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_command;
  logic [mlfq_pkg::REM_W-1:0]     in_run_length;
  logic                           out_valid;
  logic [mlfq_pkg::ID_W-1:0]      out_task_id;
  logic [mlfq_pkg::TICK_W-1:0]    out_ticks_run;
  logic                           out_finished;
  logic [mlfq_pkg::OUT_LVL_W-1:0] out_level;
  logic [mlfq_pkg::STAT_W-1:0]    out_status;
  logic                           out_last;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mlfq_pkg::TICK_W-1:0]    cfg_data;

  slice_scoreboard board;
  int unsigned     cycle_count = 0;

  multilevel_feedback_queue_scheduler uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_run_length (in_run_length),
    .out_valid     (out_valid),
    .out_task_id   (out_task_id),
    .out_ticks_run (out_ticks_run),
    .out_finished  (out_finished),
    .out_level     (out_level),
    .out_status    (out_status),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_multilevel_feedback_queue_scheduler NOT OK");
      $finish;
    end
  end

  // results are checked before the input transfer of the same edge is noted
  always @(posedge clk) begin : monitor
    slice_t seen;
    if (rst_n) begin
      if (out_valid) begin
        seen.task_id   = out_task_id;
        seen.ticks_run = out_ticks_run;
        seen.finished  = out_finished;
        seen.level     = out_level;
        seen.status    = out_status;
        seen.last      = out_last;
        board.check_slice(seen);
      end
      if (start && !busy) board.note_command(in_command, in_run_length);
    end
  end

  // start stays high on return so back-to-back commands need no second assignment
  task automatic send_item(input logic cmd, input logic [mlfq_pkg::REM_W-1:0] len);
    start         <= 1'b1;
    in_command    <= cmd;
    in_run_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start         <= 1'b0;
    in_command    <= 1'($urandom);
    in_run_length <= mlfq_pkg::REM_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [mlfq_pkg::TICK_W-1:0] q);
    cfg_valid <= 1'b1;
    cfg_data  <= q;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.quantum = q;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned items);
    int unsigned                burst;
    int unsigned                eff_q;
    int unsigned                pick;
    logic                       cmd;
    logic [mlfq_pkg::REM_W-1:0] len;
    burst = 0;
    repeat (items) begin
      if (burst == 0) begin
        if ($urandom_range(0, 49) == 0) wait_drained();
        else if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        burst = $urandom_range(1, 16);
      end
      burst--;
      eff_q = (board.quantum == '0) ? 1 : board.quantum;
      cmd   = ($urandom_range(0, 99) < 55) ? mlfq_pkg::CMD_START : mlfq_pkg::CMD_DISPATCH;
      pick  = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: len = mlfq_pkg::REM_W'($urandom_range(0, 3 * eff_q));
        3:       len = mlfq_pkg::REM_W'(eff_q * $urandom_range(1, 4));
        4:       len = mlfq_pkg::REM_W'($urandom_range(0, 1) ? eff_q + 1 : eff_q - 1);
        8:       len = '1;
        9:       len = '0;
        default: len = mlfq_pkg::REM_W'($urandom_range(0, 65535));
      endcase
      send_item(cmd, len);
    end
  endtask

  initial begin
    board = new();
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_command    <= mlfq_pkg::CMD_START;
    in_run_length <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset quantum: empty dispatch, zero-length, exact, one over, longest task
    send_item(mlfq_pkg::CMD_DISPATCH, mlfq_pkg::REM_W'($urandom));
    send_item(mlfq_pkg::CMD_START, '0);
    send_item(mlfq_pkg::CMD_START, mlfq_pkg::REM_W'(mlfq_pkg::QUANTUM_RESET));
    send_item(mlfq_pkg::CMD_START, mlfq_pkg::REM_W'(mlfq_pkg::QUANTUM_RESET) + 1'b1);
    send_item(mlfq_pkg::CMD_START, '1);
    // walk the long task down to the lowest level and twice more to saturate there
    repeat (mlfq_pkg::NUM_LEVELS) begin
      send_item(mlfq_pkg::CMD_DISPATCH, mlfq_pkg::REM_W'($urandom));
    end

    // quantum 1: fill level one, drop one, then one full-depth dispatch
    wait_drained();
    write_quantum(mlfq_pkg::TICK_W'(1));
    repeat (mlfq_pkg::QUEUE_DEPTH + 1) send_item(mlfq_pkg::CMD_START, '1);
    send_item(mlfq_pkg::CMD_DISPATCH, '0);

    wait_drained();
    write_quantum('1);
    random_phase(PHASE_ITEMS);
    wait_drained();
    write_quantum('0);
    random_phase(PHASE_ITEMS);
    wait_drained();
    write_quantum(mlfq_pkg::TICK_W'($urandom_range(2, 254)));
    random_phase(PHASE_ITEMS);
    wait_drained();
    write_quantum(mlfq_pkg::TICK_W'(1));
    random_phase(PHASE_ITEMS);
    wait_drained();
    write_quantum(mlfq_pkg::QUANTUM_RESET);
    random_phase(PHASE_ITEMS);
    wait_drained();
    write_quantum(mlfq_pkg::TICK_W'($urandom_range(0, 255)));
    random_phase(PHASE_ITEMS);
    wait_drained();

    if (board.error_count == 0) begin
      $display("tb_multilevel_feedback_queue_scheduler OK");
    end else begin
      $display("tb_multilevel_feedback_queue_scheduler NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mlfq_pkg.sv
rtl/mlfq_ram.sv
rtl/mlfq_slice.sv
rtl/multilevel_feedback_queue_scheduler.sv
dv/tb_multilevel_feedback_queue_scheduler.sv
